// ===== rtl/bws_pkg.sv =====
`default_nettype none

package bws_pkg;

	localparam int WindowLength = 15;
	localparam int QueueDepth   = 4;
	localparam int QueuePtrW    = $clog2(QueueDepth);
	localparam int QueueFillW   = $clog2(QueueDepth + 1);

	localparam int ScoreW    = 9;
	localparam int PairW     = 5;
	localparam int RowW      = 5;
	localparam int TriIdxW   = 8;
	localparam int NumAcids  = 20;
	localparam int TriSize   = NumAcids * (NumAcids + 1) / 2;
	localparam int PairCntW  = 4;
	localparam int CntW      = ($clog2(WindowLength + 1) > PairCntW) ?
		$clog2(WindowLength + 1) : PairCntW;

	localparam logic [7:0] GapSymbol = 8'h5F;
	localparam logic [RowW-1:0] NoAcid = RowW'(NumAcids);

	localparam logic [PairCntW-1:0] PairCountMax = '1;

	localparam logic signed [ScoreW-1:0] ScoreMax = 9'sd255;
	localparam logic signed [ScoreW-1:0] ScoreMin = -9'sd256;
	localparam logic signed [PairW-1:0] GapScoreReset = -5'sd4;

	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusUnknown = 2'd1;
	localparam logic [1:0] StatusLong    = 2'd2;

	typedef struct packed {
		logic [7:0] ref_residue;
		logic [7:0] query_residue;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic signed [ScoreW-1:0] window_score;
		logic [PairCntW-1:0]      pair_count;
		logic [1:0]               status;
	} out_item_t;

	// classified pair handed from front to back
	typedef struct packed {
		logic [TriIdxW-1:0] tri_idx;
		logic               gap;
		logic               unknown;
		logic               last;
	} bws_class_t;

	// letter A..Z to matrix row, order A R N D C Q E G H I L K M F P S T W Y V
	localparam logic [RowW-1:0] LetterRow [26] = '{
		5'd0, NoAcid, 5'd4, 5'd3, 5'd6, 5'd13, 5'd7, 5'd8, 5'd9, NoAcid,
		5'd11, 5'd10, 5'd12, 5'd2, NoAcid, 5'd14, 5'd5, 5'd1, 5'd15, 5'd16,
		NoAcid, 5'd19, 5'd17, NoAcid, 5'd18, NoAcid
	};

	// start of each row in the lower triangle
	localparam logic [TriIdxW-1:0] TriBase [NumAcids] = '{
		8'd0, 8'd1, 8'd3, 8'd6, 8'd10, 8'd15, 8'd21, 8'd28, 8'd36, 8'd45,
		8'd55, 8'd66, 8'd78, 8'd91, 8'd105, 8'd120, 8'd136, 8'd153, 8'd171, 8'd190
	};

	// lower triangle of the symmetric substitution matrix, row by row
	localparam logic signed [PairW-1:0] SubTri [TriSize] = '{
		 4,
		-1,  5,
		-2,  0,  6,
		-2, -2,  1,  6,
		 0, -3, -3, -3,  9,
		-1,  1,  0,  0, -3,  5,
		-1,  0,  0,  2, -4,  2,  5,
		 0, -2,  0, -1, -3, -2, -2,  6,
		-2,  0,  1, -1, -3,  0,  0, -2,  8,
		-1, -3, -3, -3, -1, -3, -3, -4, -3,  4,
		-1, -2, -3, -4, -1, -2, -3, -4, -3,  2,  4,
		-1,  2,  0, -1, -3,  1,  1, -2, -1, -3, -2,  5,
		-1, -1, -2, -3, -1,  0, -2, -3, -2,  1,  2, -1,  5,
		-2, -3, -3, -3, -2, -3, -3, -3, -1,  0,  0, -3,  0,  6,
		-1, -2, -2, -1, -3, -1, -1, -2, -2, -3, -3, -1, -2, -4,  7,
		 1, -1,  1,  0, -1,  0,  0,  0, -1, -2, -2,  0, -1, -2, -1,  4,
		 0, -1,  0, -1, -1, -1, -1, -2, -2, -1, -1, -1, -1, -2, -1,  1,  5,
		-3, -3, -4, -4, -2, -2, -3, -2, -2, -3, -2, -3, -1,  1, -4, -3, -2, 11,
		-2, -2, -2, -3, -2, -1, -2, -3,  2, -1, -1, -2, -1,  3, -3, -2, -2,  2,  7,
		 0, -3, -3, -3, -1, -2, -2, -3, -3,  3,  1, -2,  1, -1, -2, -2,  0, -3, -1,  4
	};

	function automatic logic [RowW-1:0] acid_row(input logic [7:0] sym);
		logic [7:0] c;
		begin
			c = sym;
			if (c inside {[8'h61:8'h7A]})
				c = c - 8'h20;
			if (c inside {[8'h41:8'h5A]})
				acid_row = LetterRow[5'(c - 8'h41)];
			else
				acid_row = NoAcid;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bws_front.sv =====
`default_nettype none

module bws_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire bws_pkg::in_item_t  in_data,
	input  wire logic               q_full,
	output logic                    push,
	output bws_pkg::bws_class_t     push_data
);

	logic                        valid_s1;
	bws_pkg::bws_class_t         class_s1;
	bws_pkg::bws_class_t         class_c;
	logic [bws_pkg::RowW-1:0]    row_r;
	logic [bws_pkg::RowW-1:0]    row_q;
	logic [bws_pkg::RowW-1:0]    hi;
	logic [bws_pkg::RowW-1:0]    lo;
	logic                        known;
	logic                        accept;

	always_comb begin
		row_r = bws_pkg::acid_row(in_data.ref_residue);
		row_q = bws_pkg::acid_row(in_data.query_residue);
		known = (row_r != bws_pkg::NoAcid) && (row_q != bws_pkg::NoAcid);
		// symmetric table: index by (larger row, smaller row)
		if (row_r >= row_q) begin
			hi = row_r;
			lo = row_q;
		end else begin
			hi = row_q;
			lo = row_r;
		end
		if (!known) begin
			hi = '0;
			lo = '0;
		end
		class_c.gap = (in_data.ref_residue == bws_pkg::GapSymbol) ||
			(in_data.query_residue == bws_pkg::GapSymbol);
		class_c.unknown = !class_c.gap && !known;
		class_c.tri_idx = bws_pkg::TriBase[hi] + bws_pkg::TriIdxW'(lo);
		class_c.last = in_data.last;
	end

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_data = class_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			class_s1 <= class_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bws_queue.sv =====
`default_nettype none

module bws_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire bws_pkg::bws_class_t wr_data,
	input  wire logic                rd_en,
	output bws_pkg::bws_class_t      rd_data,
	output logic                     full,
	output logic                     empty
);

	bws_pkg::bws_class_t              mem_q [bws_pkg::QueueDepth];
	logic [bws_pkg::QueuePtrW-1:0]    wr_ptr_q;
	logic [bws_pkg::QueuePtrW-1:0]    rd_ptr_q;
	logic [bws_pkg::QueueFillW-1:0]   fill_q;

	assign full    = (fill_q == bws_pkg::QueueFillW'(bws_pkg::QueueDepth));
	assign empty   = (fill_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == bws_pkg::QueuePtrW'(bws_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == bws_pkg::QueuePtrW'(bws_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				fill_q <= fill_q + 1'b1;
			else if (rd_en && !wr_en)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty) else $error("queue read while empty");

	a_fill_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count lost a transfer");

endmodule

`default_nettype wire

// ===== rtl/bws_back.sv =====
`default_nettype none

module bws_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic signed [bws_pkg::PairW-1:0] cfg_wr_data,
	input  wire logic                       q_empty,
	input  wire bws_pkg::bws_class_t        q_data,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output bws_pkg::out_item_t              out_data
);

	logic signed [bws_pkg::PairW-1:0]  gap_score_q;
	logic signed [bws_pkg::ScoreW-1:0] acc_q;
	logic [bws_pkg::CntW-1:0]          cnt_q;
	logic [1:0]                        status_q;
	logic                              out_valid_q;
	bws_pkg::out_item_t                out_q;

	logic signed [bws_pkg::PairW-1:0]  pair;
	logic signed [bws_pkg::ScoreW:0]   sum;
	logic signed [bws_pkg::ScoreW-1:0] acc_n;
	logic [bws_pkg::CntW-1:0]          cnt_n;
	logic [1:0]                        status_n;
	logic                              slot_free;

	// only a window's final pair needs the output register
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = !q_empty && (!q_data.last || slot_free);

	always_comb begin
		pair     = '0;
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		status_n = status_q;
		if (q_data.gap)
			pair = gap_score_q;
		else if (!q_data.unknown)
			pair = bws_pkg::SubTri[q_data.tri_idx];
		sum = {acc_q[bws_pkg::ScoreW-1], acc_q} +
			{{(bws_pkg::ScoreW + 1 - bws_pkg::PairW){pair[bws_pkg::PairW-1]}}, pair};
		if (cnt_q >= bws_pkg::CntW'(bws_pkg::WindowLength)) begin
			status_n = bws_pkg::StatusLong;
		end else begin
			if (q_data.unknown && (status_q < bws_pkg::StatusUnknown))
				status_n = bws_pkg::StatusUnknown;
			// saturate when the top two bits disagree
			if (sum[bws_pkg::ScoreW] != sum[bws_pkg::ScoreW-1])
				acc_n = sum[bws_pkg::ScoreW] ? bws_pkg::ScoreMin : bws_pkg::ScoreMax;
			else
				acc_n = sum[bws_pkg::ScoreW-1:0];
			cnt_n = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_score_q <= bws_pkg::GapScoreReset;
			acc_q       <= '0;
			cnt_q       <= '0;
			status_q    <= bws_pkg::StatusOk;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				gap_score_q <= cfg_wr_data;
			if (pop && q_data.last) begin
				acc_q       <= '0;
				cnt_q       <= '0;
				status_q    <= bws_pkg::StatusOk;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					acc_q    <= acc_n;
					cnt_q    <= cnt_n;
					status_q <= status_n;
				end
				if (!out_stall)
					out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_data.last) begin
			out_q.window_score <= acc_n;
			out_q.pair_count   <= (cnt_n > bws_pkg::CntW'(bws_pkg::PairCountMax)) ?
				bws_pkg::PairCountMax : cnt_n[bws_pkg::PairCntW-1:0];
			out_q.status       <= status_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bws_pkg::CntW'(bws_pkg::WindowLength))
		else $error("pair count ran past the window length");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_data.last) |=> (cnt_q == '0) && (acc_q == '0) &&
		(status_q == bws_pkg::StatusOk) && out_valid_q)
		else $error("window state not cleared after final pair");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(pop && q_data.last))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/peptide_blosum62_window_score.sv =====
// channel   | valid / stall         | payload                        | transfer on
// ----------+-----------------------+--------------------------------+------------------
// in        | in_valid / in_stall   | in_data  (ref, query, last)    | valid & !stall
// out       | out_valid / out_stall | out_data (score, count, status)| valid & !stall
// cfg       | cfg_wr_en             | cfg_wr_data (gap score)        | cfg_wr_en high
//
// One residue pair per cycle while the queue has room; the table lookup and
// saturating add are combinational in the back end. A pair is registered in the
// front before it enters the queue; popping a final pair registers its result.
// arst_n clears the window state and sets the gap score to -4.
// A 4-entry queue decouples classification from scoring; out_stall only holds
// the back end when a final pair finds the result register still occupied.
`default_nettype none

module peptide_blosum62_window_score (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire bws_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output bws_pkg::out_item_t                 out_data,
	input  wire logic                          cfg_wr_en,
	input  wire logic signed [bws_pkg::PairW-1:0] cfg_wr_data
);

	logic                push;
	bws_pkg::bws_class_t push_data;
	logic                pop;
	bws_pkg::bws_class_t pop_data;
	logic                q_full;
	logic                q_empty;

	bws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	bws_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.rd_en   (pop),
		.rd_data (pop_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	bws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (q_empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire
